// ----- hw/rtl/rtp_pkg.sv -----
// Package for the radix-40 text packer: constants, character map and types.
// Depends on nothing; imported by radix40_text_packer.
`default_nettype none

package rtp_pkg;

  // Geometry of the packed output
  localparam int unsigned MAX_WORDS = 63;
  localparam int unsigned LIMIT_MAX = 3 * MAX_WORDS;
  localparam int unsigned WORDS_W   = $clog2(MAX_WORDS + 1);

  // Field widths
  localparam int unsigned CHAR_W  = 16;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned LIMIT_W = 8;
  localparam int unsigned CODE_W  = 6;

  // Register reset and character constants
  localparam logic [LIMIT_W-1:0] CHAR_LIMIT_RST = LIMIT_W'(LIMIT_MAX);
  localparam logic [CHAR_W-1:0]  HIGH_MASK      = 16'hFF80;
  localparam logic [CODE_W-1:0]  RX_HYPHEN      = 6'd2;
  localparam logic [WORD_W-1:0]  WEIGHT_HI      = 16'd1600;
  localparam logic [WORD_W-1:0]  WEIGHT_MID     = 16'd40;

  // Divide by three for values below 256: (x * 171) >> 9
  localparam logic [7:0] DIV3_MUL   = 8'd171;
  localparam int unsigned DIV3_SHIFT = 9;

  typedef struct packed {
    logic              bad;
    logic [CODE_W-1:0] code;
  } rx_map_t;

  // Map one character code to its radix-40 code; flag anything outside the set
  function automatic rx_map_t map_char(input logic [CHAR_W-1:0] c);
    rx_map_t m;
    logic [6:0] lo;
    lo     = c[6:0];
    m.bad  = 1'b0;
    m.code = RX_HYPHEN;
    if ((c & HIGH_MASK) != '0) begin
      m.bad = 1'b1;
    end else if (lo == 7'h20) begin
      m.code = 6'd0;
    end else if (lo == 7'h2C) begin
      m.code = 6'd1;
    end else if (lo == 7'h2D) begin
      m.code = 6'd2;
    end else if (lo == 7'h2E) begin
      m.code = 6'd3;
    end else if (lo >= 7'h30 && lo <= 7'h39) begin
      m.code = CODE_W'(lo - 7'h30 + 7'd4);
    end else if (lo >= 7'h41 && lo <= 7'h5A) begin
      m.code = CODE_W'(lo - 7'h41 + 7'd14);
    end else if (lo >= 7'h61 && lo <= 7'h7A) begin
      m.code = CODE_W'(lo - 7'h61 + 7'd14);
    end else begin
      m.bad = 1'b1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/radix40_text_packer.sv -----
// Radix-40 text packer top level: character map, word accumulation and
// end-of-string fill sequencing. Depends on rtp_pkg.
//
// One character is taken per cycle while in_ready is high and is folded into
// the current word in the same cycle; a full word other than the last of a
// string lands in the output register the cycle after its third character
// is accepted. The terminator (or a character past the limit) ends the
// string and produces ceil(limit/3) - words_already_sent results, at least
// one, one per cycle from the output register while out_ready is high;
// input is held off until the last fill result is loaded. Input and output
// are parted by the output register: a new character is accepted in the
// same cycle the previous result is taken. The user writes the character
// limit through the cfg port only while the block is idle; the block does
// not enforce this. It takes effect at once; values above 189 behave as 189.
`default_nettype none

module radix40_text_packer (
  input  wire                         clk,
  input  wire                         rst_n,
  // character input
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [rtp_pkg::CHAR_W-1:0]  in_char_code,
  // packed word output
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [rtp_pkg::WORD_W-1:0]  out_packed_word,
  output logic                        out_word_valid,
  output logic                        out_last_word,
  output logic                        out_status,
  // configuration
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [rtp_pkg::LIMIT_W-1:0] cfg_char_limit
);
  import rtp_pkg::*;

  // Registers
  logic [LIMIT_W-1:0] char_limit_r;
  logic [WORD_W-1:0]  acc_r,        acc_nxt;
  logic [1:0]         pos_r,        pos_nxt;
  logic [LIMIT_W-1:0] chars_r,      chars_nxt;
  logic [WORDS_W-1:0] words_r,      words_nxt;
  logic               illegal_r,    illegal_nxt;
  logic               skip_r,       skip_nxt;
  logic [WORDS_W-1:0] fill_cnt_r,   fill_cnt_nxt;
  logic               fill_stat_r,  fill_stat_nxt;
  logic               out_valid_r,  out_valid_nxt;
  logic [WORD_W-1:0]  out_word_r,   out_word_nxt;
  logic               out_wv_r,     out_wv_nxt;
  logic               out_last_r,   out_last_nxt;
  logic               out_stat_r,   out_stat_nxt;

  // Limit and word count
  logic [LIMIT_W-1:0] lim;
  logic [8:0]         lim_p2;
  logic [16:0]        div_prod;
  logic [WORDS_W-1:0] total;
  logic [WORDS_W-1:0] rem_raw;
  logic [WORDS_W-1:0] rem;

  // Character path
  logic               in_fire;
  logic               out_free;
  logic               fill_active;
  logic               too_long;
  logic               is_term;
  rx_map_t            mapped;
  logic [WORD_W-1:0]  base_acc;
  logic [1:0]         base_pos;
  logic [1:0]         pos_inc;
  logic [WORD_W-1:0]  term;
  logic [WORD_W-1:0]  acc_sum;
  logic               illegal_upd;
  logic               hold_final;
  logic               fin_stat;

  assign fill_active = (fill_cnt_r != '0);
  assign out_free    = !out_valid_r || out_ready;
  assign in_ready    = !fill_active && out_free;
  assign in_fire     = in_valid && in_ready;
  assign cfg_ready   = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_packed_word = out_word_r;
  assign out_word_valid  = out_wv_r;
  assign out_last_word   = out_last_r;
  assign out_status      = out_stat_r;

  // Saturate the limit and count the words of a full string
  always_comb begin
    lim      = (char_limit_r > LIMIT_W'(LIMIT_MAX)) ? LIMIT_W'(LIMIT_MAX) : char_limit_r;
    lim_p2   = {1'b0, lim} + 9'd2;
    div_prod = lim_p2 * {1'b0, DIV3_MUL};
    total    = div_prod[DIV3_SHIFT +: WORDS_W];
    rem_raw  = (total > words_r) ? total - words_r : '0;
    rem      = (rem_raw == '0 && pos_r != 2'd0) ? WORDS_W'(1) : rem_raw;
  end

  // Map the character and fold it into the current word
  always_comb begin
    is_term     = (in_char_code == '0);
    too_long    = (chars_r >= lim);
    mapped      = map_char(in_char_code);
    illegal_upd = illegal_r || mapped.bad;
    base_acc    = (pos_r == 2'd3) ? '0 : acc_r;
    base_pos    = (pos_r == 2'd3) ? 2'd0 : pos_r;
    case (base_pos)
      2'd0:    term = WORD_W'(WORD_W'(mapped.code) * WEIGHT_HI);
      2'd1:    term = WORD_W'(WORD_W'(mapped.code) * WEIGHT_MID);
      default: term = WORD_W'(mapped.code);
    endcase
    acc_sum    = base_acc + term;
    pos_inc    = base_pos + 2'd1;
    hold_final = ({1'b0, words_r} + 7'd1) >= {1'b0, total};
    fin_stat   = is_term ? illegal_r : 1'b1;
  end

  // Next state: accept a character, or drain the fill words
  always_comb begin
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    chars_nxt     = chars_r;
    words_nxt     = words_r;
    illegal_nxt   = illegal_r;
    skip_nxt      = skip_r;
    fill_cnt_nxt  = fill_cnt_r;
    fill_stat_nxt = fill_stat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    out_wv_nxt    = out_wv_r;
    out_last_nxt  = out_last_r;
    out_stat_nxt  = out_stat_r;

    if (in_fire) begin
      if (skip_r) begin
        // drop everything up to the terminator
        if (is_term) begin
          skip_nxt = 1'b0;
        end
      end else if (is_term || too_long) begin
        // end the string: pending word first, then zero fill words
        skip_nxt      = !is_term;
        out_valid_nxt = 1'b1;
        out_stat_nxt  = fin_stat;
        if (rem == '0) begin
          out_word_nxt = '0;
          out_wv_nxt   = 1'b0;
          out_last_nxt = 1'b1;
        end else begin
          out_word_nxt  = (pos_r != 2'd0) ? acc_r : '0;
          out_wv_nxt    = 1'b1;
          out_last_nxt  = (rem == WORDS_W'(1));
          fill_cnt_nxt  = rem - WORDS_W'(1);
          fill_stat_nxt = fin_stat;
        end
        acc_nxt     = '0;
        pos_nxt     = 2'd0;
        chars_nxt   = '0;
        words_nxt   = '0;
        illegal_nxt = 1'b0;
      end else begin
        illegal_nxt = illegal_upd;
        chars_nxt   = chars_r + LIMIT_W'(1);
        if (pos_inc == 2'd3 && !hold_final) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = acc_sum;
          out_wv_nxt    = 1'b1;
          out_last_nxt  = 1'b0;
          out_stat_nxt  = illegal_upd;
          words_nxt     = words_r + WORDS_W'(1);
          acc_nxt       = '0;
          pos_nxt       = 2'd0;
        end else begin
          acc_nxt = acc_sum;
          pos_nxt = pos_inc;
        end
      end
    end else if (fill_active && out_free) begin
      // advance the fill sequence by one zero word
      out_valid_nxt = 1'b1;
      out_word_nxt  = '0;
      out_wv_nxt    = 1'b1;
      out_last_nxt  = (fill_cnt_r == WORDS_W'(1));
      out_stat_nxt  = fill_stat_r;
      fill_cnt_nxt  = fill_cnt_r - WORDS_W'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_limit_r <= CHAR_LIMIT_RST;
      acc_r        <= '0;
      pos_r        <= 2'd0;
      chars_r      <= '0;
      words_r      <= '0;
      illegal_r    <= 1'b0;
      skip_r       <= 1'b0;
      fill_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        char_limit_r <= cfg_char_limit;
      end
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      chars_r     <= chars_nxt;
      words_r     <= words_nxt;
      illegal_r   <= illegal_nxt;
      skip_r      <= skip_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    fill_stat_r <= fill_stat_nxt;
    out_word_r  <= out_word_nxt;
    out_wv_r    <= out_wv_nxt;
    out_last_r  <= out_last_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  // Checks
  a_fill_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    fill_active |-> out_valid_r)
    else $error("fill sequence running with empty output register");

  a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> (chars_r == '0 && pos_r == 2'd0 && words_r == '0))
    else $error("string state not cleared while skipping");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_wv_r) |-> (out_last_r && out_word_r == '0))
    else $error("empty-string result not marked last");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_word_r)
      && $stable(out_last_r)))
    else $error("stalled result overwritten");

endmodule

`default_nettype wire
